@@ design/dpp_pkg.sv @@
// shared widths, register codes and word types for the depth pixel to point block
// no dependencies; every other design file refers to this package by scoped names
package dpp_pkg;

    // field and configuration widths
    localparam int FOCAL_W = 24;
    localparam int DIM_W   = 11;
    localparam int POS_W   = 10;
    localparam int DEPTH_W = 16;
    localparam int OUT_W   = 21;

    // internal datapath widths
    localparam int OFS_W      = 11;                 // |2*col - width|
    localparam int TA_W       = FOCAL_W + OFS_W;    // focal times offset
    localparam int TC_W       = 2 * FOCAL_W + 1;    // 2*fx*fy
    localparam int TERM_W     = 31;                 // normalized term
    localparam int NORM_MSB   = 30;                 // leading one position after normalizing
    localparam int SHIFT_W    = 6;
    localparam int SQ_W       = 2 * TERM_W;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQ_REM_W   = 35;
    localparam int NUM_W      = DEPTH_W + 5;        // depth*32
    localparam int PROD_W     = NUM_W + TERM_W;
    localparam int DVD_W      = PROD_W + 2;         // 2*P + 3*S
    localparam int DVS_W      = ROOT_W + 3;         // 6*S
    localparam int QUO_W      = 20;
    localparam int DIV_REM_W  = DVS_W + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    // per-word side information that rides along the pipeline
    typedef struct packed {
        logic               neg_u;
        logic               neg_v;
        logic [DEPTH_W-1:0] depth;
    } t_tag;

    // normalized x, y and z terms
    typedef struct packed {
        logic [TERM_W-1:0] ta;
        logic [TERM_W-1:0] tb;
        logic [TERM_W-1:0] tc;
    } t_terms;

endpackage

@@ design/dpp_front.sv @@
// front pipeline: centre offsets, focal products, normalization and sum of squares
// depends on dpp_pkg
module dpp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [dpp_pkg::POS_W-1:0]    i_row,
    input  logic [dpp_pkg::POS_W-1:0]    i_col,
    input  logic [dpp_pkg::DEPTH_W-1:0]  i_depth,
    input  logic [dpp_pkg::FOCAL_W-1:0]  i_focal_x,
    input  logic [dpp_pkg::FOCAL_W-1:0]  i_focal_y,
    input  logic [dpp_pkg::DIM_W-1:0]    i_width,
    input  logic [dpp_pkg::DIM_W-1:0]    i_height,
    output logic                         o_valid,
    output dpp_pkg::t_tag                o_tag,
    output dpp_pkg::t_terms              o_terms,
    output logic [dpp_pkg::SUM_W-1:0]    o_sumsq
);

    localparam int DIFF_W = dpp_pkg::DIM_W + 1;

    // stage 1: signed half-pixel offsets
    logic                          r1_valid;
    dpp_pkg::t_tag                 r1_tag;
    logic [dpp_pkg::OFS_W-1:0]     r1_au, r1_av;
    logic [DIFF_W-1:0]             du, dv;
    dpp_pkg::t_tag                 n1_tag;

    always_comb begin
        du = DIFF_W'({i_col, 1'b0}) - DIFF_W'(i_width);
        dv = DIFF_W'({i_row, 1'b0}) - DIFF_W'(i_height);
        n1_tag.neg_u = du[DIFF_W-1];
        n1_tag.neg_v = dv[DIFF_W-1];
        n1_tag.depth = i_depth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tag <= n1_tag;
            r1_au  <= dpp_pkg::OFS_W'(du[DIFF_W-1] ? (DIFF_W'(0) - du) : du);
            r1_av  <= dpp_pkg::OFS_W'(dv[DIFF_W-1] ? (DIFF_W'(0) - dv) : dv);
        end
    end

    // stage 2: focal products
    logic                          r2_valid;
    dpp_pkg::t_tag                 r2_tag;
    logic [dpp_pkg::TA_W-1:0]      r2_ta, r2_tb;
    logic [dpp_pkg::TC_W-1:0]      r2_tc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_tag <= r1_tag;
            r2_ta  <= dpp_pkg::TA_W'(i_focal_y) * dpp_pkg::TA_W'(r1_au);
            r2_tb  <= dpp_pkg::TA_W'(i_focal_x) * dpp_pkg::TA_W'(r1_av);
            r2_tc  <= {(2 * dpp_pkg::FOCAL_W)'(i_focal_x)
                       * (2 * dpp_pkg::FOCAL_W)'(i_focal_y), 1'b0};
        end
    end

    // stage 3: leading one of the largest term, shift direction and amount
    logic                          r3_valid;
    dpp_pkg::t_tag                 r3_tag;
    logic [dpp_pkg::TC_W-1:0]      r3_ta, r3_tb, r3_tc;
    logic                          r3_left, r3_zero;
    logic [dpp_pkg::SHIFT_W-1:0]   r3_amt;
    logic [dpp_pkg::TC_W-1:0]      orv;
    logic [dpp_pkg::SHIFT_W-1:0]   msb;
    logic                          n3_left;
    logic [dpp_pkg::SHIFT_W-1:0]   n3_amt;

    always_comb begin
        orv = dpp_pkg::TC_W'(r2_ta) | dpp_pkg::TC_W'(r2_tb) | r2_tc;
        msb = '0;
        for (int i = 0; i < dpp_pkg::TC_W; i++) begin
            if (orv[i]) msb = dpp_pkg::SHIFT_W'(i);
        end
        n3_left = (msb <= dpp_pkg::SHIFT_W'(dpp_pkg::NORM_MSB));
        n3_amt  = n3_left ? (dpp_pkg::SHIFT_W'(dpp_pkg::NORM_MSB) - msb)
                          : (msb - dpp_pkg::SHIFT_W'(dpp_pkg::NORM_MSB));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_tag  <= r2_tag;
            r3_ta   <= dpp_pkg::TC_W'(r2_ta);
            r3_tb   <= dpp_pkg::TC_W'(r2_tb);
            r3_tc   <= r2_tc;
            r3_left <= n3_left;
            r3_amt  <= n3_amt;
            r3_zero <= (orv == '0);
        end
    end

    // stage 4: common shift into the normalized range
    function automatic logic [dpp_pkg::TERM_W-1:0] norm_term(
        input logic [dpp_pkg::TC_W-1:0]    v,
        input logic                        left,
        input logic [dpp_pkg::SHIFT_W-1:0] amt
    );
        logic [dpp_pkg::TC_W-1:0] s;
        s = left ? (v << amt) : (v >> amt);
        return s[dpp_pkg::TERM_W-1:0];
    endfunction

    logic                          r4_valid;
    dpp_pkg::t_tag                 r4_tag;
    dpp_pkg::t_terms               r4_terms, n4_terms;

    always_comb begin
        // all terms zero: put the point on the optical axis (z term equals the root)
        if (r3_zero) begin
            n4_terms.ta = '0;
            n4_terms.tb = '0;
            n4_terms.tc = dpp_pkg::TERM_W'(1) << dpp_pkg::NORM_MSB;
        end else begin
            n4_terms.ta = norm_term(r3_ta, r3_left, r3_amt);
            n4_terms.tb = norm_term(r3_tb, r3_left, r3_amt);
            n4_terms.tc = norm_term(r3_tc, r3_left, r3_amt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_tag   <= r3_tag;
            r4_terms <= n4_terms;
        end
    end

    // stage 5: squares
    logic                          r5_valid;
    dpp_pkg::t_tag                 r5_tag;
    dpp_pkg::t_terms               r5_terms;
    logic [dpp_pkg::SQ_W-1:0]      r5_sa, r5_sb, r5_sc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_tag   <= r4_tag;
            r5_terms <= r4_terms;
            r5_sa    <= dpp_pkg::SQ_W'(r4_terms.ta) * dpp_pkg::SQ_W'(r4_terms.ta);
            r5_sb    <= dpp_pkg::SQ_W'(r4_terms.tb) * dpp_pkg::SQ_W'(r4_terms.tb);
            r5_sc    <= dpp_pkg::SQ_W'(r4_terms.tc) * dpp_pkg::SQ_W'(r4_terms.tc);
        end
    end

    // stage 6: sum of squares
    logic                          r6_valid;
    dpp_pkg::t_tag                 r6_tag;
    dpp_pkg::t_terms               r6_terms;
    logic [dpp_pkg::SUM_W-1:0]     r6_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_tag   <= r5_tag;
            r6_terms <= r5_terms;
            r6_sum   <= dpp_pkg::SUM_W'(r5_sa) + dpp_pkg::SUM_W'(r5_sb)
                      + dpp_pkg::SUM_W'(r5_sc);
        end
    end

    assign o_valid = r6_valid;
    assign o_tag   = r6_tag;
    assign o_terms = r6_terms;
    assign o_sumsq = r6_sum;

endmodule

@@ design/dpp_sqrt.sv @@
// pipelined integer square root, one root bit per stage
// depends on dpp_pkg
module dpp_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [dpp_pkg::SUM_W-1:0]    i_radicand,
    input  dpp_pkg::t_tag                i_tag,
    input  dpp_pkg::t_terms              i_terms,
    output logic                         o_valid,
    output logic [dpp_pkg::ROOT_W-1:0]   o_root,
    output dpp_pkg::t_tag                o_tag,
    output dpp_pkg::t_terms              o_terms
);

    localparam int STAGES = dpp_pkg::ROOT_W;

    logic                           r_valid [STAGES];
    logic [dpp_pkg::SQ_REM_W-1:0]   r_rem   [STAGES];
    logic [dpp_pkg::ROOT_W-1:0]     r_root  [STAGES];
    logic [dpp_pkg::SUM_W-1:0]      r_rad   [STAGES];
    dpp_pkg::t_tag                  r_tag   [STAGES];
    dpp_pkg::t_terms                r_terms [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                           v_in;
        logic [dpp_pkg::SQ_REM_W-1:0]   rem_in, cur, trial;
        logic [dpp_pkg::ROOT_W-1:0]     root_in;
        logic [dpp_pkg::SUM_W-1:0]      rad_in;
        dpp_pkg::t_tag                  tag_in;
        dpp_pkg::t_terms                terms_in;
        logic                           take;

        if (k == 0) begin : g_first
            assign v_in     = i_valid;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign rad_in   = i_radicand;
            assign tag_in   = i_tag;
            assign terms_in = i_terms;
        end else begin : g_next
            assign v_in     = r_valid[k-1];
            assign rem_in   = r_rem[k-1];
            assign root_in  = r_root[k-1];
            assign rad_in   = r_rad[k-1];
            assign tag_in   = r_tag[k-1];
            assign terms_in = r_terms[k-1];
        end

        // bring down two radicand bits and try the next root bit
        assign cur   = {rem_in[dpp_pkg::SQ_REM_W-3:0],
                        rad_in[dpp_pkg::SUM_W-1:dpp_pkg::SUM_W-2]};
        assign trial = dpp_pkg::SQ_REM_W'({root_in, 2'b01});
        assign take  = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]   <= take ? (cur - trial) : cur;
                r_root[k]  <= {root_in[dpp_pkg::ROOT_W-2:0], take};
                r_rad[k]   <= {rad_in[dpp_pkg::SUM_W-3:0], 2'b00};
                r_tag[k]   <= tag_in;
                r_terms[k] <= terms_in;
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_root  = r_root[STAGES-1];
    assign o_tag   = r_tag[STAGES-1];
    assign o_terms = r_terms[STAGES-1];

endmodule

@@ design/dpp_div.sv @@
// scaling products and three-lane pipelined divider, one quotient bit per stage
// depends on dpp_pkg
module dpp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [dpp_pkg::ROOT_W-1:0]   i_root,
    input  dpp_pkg::t_tag                i_tag,
    input  dpp_pkg::t_terms              i_terms,
    output logic                         o_valid,
    output dpp_pkg::t_tag                o_tag,
    output logic [dpp_pkg::QUO_W-1:0]    o_mag [3]
);

    localparam int LANES  = 3;
    localparam int STAGES = dpp_pkg::QUO_W;

    logic [dpp_pkg::TERM_W-1:0] term_in [LANES];
    logic [dpp_pkg::NUM_W-1:0]  num;

    assign term_in[0] = i_terms.ta;
    assign term_in[1] = i_terms.tb;
    assign term_in[2] = i_terms.tc;
    assign num        = {i_tag.depth, 5'b00000};

    // stage a: depth times term, divisor 6*S
    logic                          ra_valid;
    dpp_pkg::t_tag                 ra_tag;
    logic [dpp_pkg::ROOT_W-1:0]    ra_root;
    logic [dpp_pkg::DVS_W-1:0]     ra_dvs;
    logic [dpp_pkg::PROD_W-1:0]    ra_prod [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_valid <= 1'b0;
        end else if (i_en) begin
            ra_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_tag  <= i_tag;
            ra_root <= i_root;
            ra_dvs  <= {1'b0, i_root, 2'b00} + {2'b00, i_root, 1'b0};
            for (int l = 0; l < LANES; l++) begin
                ra_prod[l] <= dpp_pkg::PROD_W'(num) * dpp_pkg::PROD_W'(term_in[l]);
            end
        end
    end

    // stage b: dividend 2*P + 3*S for round half up
    logic                          rb_valid;
    dpp_pkg::t_tag                 rb_tag;
    logic [dpp_pkg::DVS_W-1:0]     rb_dvs;
    logic [dpp_pkg::DVD_W-1:0]     rb_dvd [LANES];
    logic [dpp_pkg::DVD_W-1:0]     three_s;

    assign three_s = dpp_pkg::DVD_W'(ra_root) + dpp_pkg::DVD_W'({ra_root, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_valid <= 1'b0;
        end else if (i_en) begin
            rb_valid <= ra_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rb_tag <= ra_tag;
            rb_dvs <= ra_dvs;
            for (int l = 0; l < LANES; l++) begin
                rb_dvd[l] <= dpp_pkg::DVD_W'({ra_prod[l], 1'b0}) + three_s;
            end
        end
    end

    // restoring division stages; the quotient is known to fit in QUO_W bits
    logic                            r_valid [STAGES];
    dpp_pkg::t_tag                   r_tag   [STAGES];
    logic [dpp_pkg::DVS_W-1:0]       r_dvs   [STAGES];
    logic [dpp_pkg::DIV_REM_W-1:0]   r_rem   [STAGES][LANES];
    logic [dpp_pkg::QUO_W-1:0]       r_low   [STAGES][LANES];
    logic [dpp_pkg::QUO_W-1:0]       r_quo   [STAGES][LANES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                            v_in;
        dpp_pkg::t_tag                   tag_in;
        logic [dpp_pkg::DVS_W-1:0]       dvs_in;
        logic [dpp_pkg::DIV_REM_W-1:0]   rem_in [LANES];
        logic [dpp_pkg::QUO_W-1:0]       low_in [LANES];
        logic [dpp_pkg::QUO_W-1:0]       quo_in [LANES];

        if (k == 0) begin : g_first
            assign v_in   = rb_valid;
            assign tag_in = rb_tag;
            assign dvs_in = rb_dvs;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_in[l] = dpp_pkg::DIV_REM_W'(
                    rb_dvd[l][dpp_pkg::DVD_W-1:dpp_pkg::QUO_W]);
                assign low_in[l] = rb_dvd[l][dpp_pkg::QUO_W-1:0];
                assign quo_in[l] = '0;
            end
        end else begin : g_next
            assign v_in   = r_valid[k-1];
            assign tag_in = r_tag[k-1];
            assign dvs_in = r_dvs[k-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_in[l] = r_rem[k-1][l];
                assign low_in[l] = r_low[k-1][l];
                assign quo_in[l] = r_quo[k-1][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k] <= tag_in;
                r_dvs[k] <= dvs_in;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane_step
            logic [dpp_pkg::DIV_REM_W-1:0] cur;
            logic                          take;

            // shift in the next dividend bit and subtract if it fits
            assign cur  = {rem_in[l][dpp_pkg::DIV_REM_W-2:0],
                           low_in[l][dpp_pkg::QUO_W-1]};
            assign take = (cur >= dpp_pkg::DIV_REM_W'(dvs_in));

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k][l] <= take ? (cur - dpp_pkg::DIV_REM_W'(dvs_in)) : cur;
                    r_low[k][l] <= {low_in[l][dpp_pkg::QUO_W-2:0], 1'b0};
                    r_quo[k][l] <= {quo_in[l][dpp_pkg::QUO_W-2:0], take};
                end
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_tag   = r_tag[STAGES-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_mag[l] = r_quo[STAGES-1][l];
    end

endmodule

@@ design/depth_pixel_to_point.sv @@
// top level of the depth pixel to point block: configuration registers, pipeline, output register
// depends on dpp_pkg, dpp_front, dpp_sqrt and dpp_div
//
// Projects one depth pixel (row, col, raw depth) to an (x, y, z) point in signed units of
// 1/256 with distance depth*125/3000, using focal lengths in Q12.12 and the image centre
// from the configured width and height (each capped at MAX_DIM). The block is a fully
// pipelined datapath of 61 register stages: it takes one word per clock while the output
// register can take a word, and most of its stages are the 32 one-bit stages of the square
// root and the 20 one-bit stages of the divider. When the output word is not taken the
// whole pipeline holds, and input ready drops until it moves again. Configuration writes
// take effect at once and belong only to an idle pipeline.
module depth_pixel_to_point #(
    parameter int MAX_DIM = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [dpp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dpp_pkg::FOCAL_W-1:0]       i_cfg_data,
    // pixel input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [dpp_pkg::POS_W-1:0]         i_row,
    input  logic [dpp_pkg::POS_W-1:0]         i_col,
    input  logic [dpp_pkg::DEPTH_W-1:0]       i_depth,
    // point output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [dpp_pkg::OUT_W-1:0]  o_point_x,
    output logic signed [dpp_pkg::OUT_W-1:0]  o_point_y,
    output logic signed [dpp_pkg::OUT_W-1:0]  o_point_z
);

    // configuration registers
    logic [dpp_pkg::FOCAL_W-1:0] r_focal_x, r_focal_y;
    logic [dpp_pkg::DIM_W-1:0]   r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x <= dpp_pkg::FOCAL_W'(1212585);
            r_focal_y <= dpp_pkg::FOCAL_W'(1215853);
            r_width   <= dpp_pkg::DIM_W'(320);
            r_height  <= dpp_pkg::DIM_W'(240);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dpp_pkg::CFG_FOCAL_X:      r_focal_x <= i_cfg_data;
                dpp_pkg::CFG_FOCAL_Y:      r_focal_y <= i_cfg_data;
                dpp_pkg::CFG_IMAGE_WIDTH:  r_width   <= i_cfg_data[dpp_pkg::DIM_W-1:0];
                dpp_pkg::CFG_IMAGE_HEIGHT: r_height  <= i_cfg_data[dpp_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // oversized frames count as the largest supported size
    logic [dpp_pkg::DIM_W-1:0] width_eff, height_eff;

    assign width_eff  = (32'(r_width) > 32'(MAX_DIM)) ? dpp_pkg::DIM_W'(MAX_DIM) : r_width;
    assign height_eff = (32'(r_height) > 32'(MAX_DIM)) ? dpp_pkg::DIM_W'(MAX_DIM) : r_height;

    // global pipeline advance: moves whenever the output register can take a word
    logic r_out_valid;
    logic pipe_en;

    assign pipe_en    = !r_out_valid || i_out_ready;
    assign o_in_ready = pipe_en;

    // front end
    logic                        front_valid;
    dpp_pkg::t_tag               front_tag;
    dpp_pkg::t_terms             front_terms;
    logic [dpp_pkg::SUM_W-1:0]   front_sum;

    dpp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_valid   (i_in_valid),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_depth   (i_depth),
        .i_focal_x (r_focal_x),
        .i_focal_y (r_focal_y),
        .i_width   (width_eff),
        .i_height  (height_eff),
        .o_valid   (front_valid),
        .o_tag     (front_tag),
        .o_terms   (front_terms),
        .o_sumsq   (front_sum)
    );

    // square root of the sum of squares
    logic                        sqrt_valid;
    logic [dpp_pkg::ROOT_W-1:0]  sqrt_root;
    dpp_pkg::t_tag               sqrt_tag;
    dpp_pkg::t_terms             sqrt_terms;

    dpp_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (pipe_en),
        .i_valid    (front_valid),
        .i_radicand (front_sum),
        .i_tag      (front_tag),
        .i_terms    (front_terms),
        .o_valid    (sqrt_valid),
        .o_root     (sqrt_root),
        .o_tag      (sqrt_tag),
        .o_terms    (sqrt_terms)
    );

    // scaling and division
    logic                        div_valid;
    dpp_pkg::t_tag               div_tag;
    logic [dpp_pkg::QUO_W-1:0]   div_mag [3];

    dpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (sqrt_valid),
        .i_root  (sqrt_root),
        .i_tag   (sqrt_tag),
        .i_terms (sqrt_terms),
        .o_valid (div_valid),
        .o_tag   (div_tag),
        .o_mag   (div_mag)
    );

    // output register with signs applied
    logic [dpp_pkg::OUT_W-1:0] r_point_x, r_point_y, r_point_z;
    logic [dpp_pkg::OUT_W-1:0] mag_x, mag_y;

    assign mag_x = dpp_pkg::OUT_W'(div_mag[0]);
    assign mag_y = dpp_pkg::OUT_W'(div_mag[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_point_x <= div_tag.neg_u ? (dpp_pkg::OUT_W'(0) - mag_x) : mag_x;
            r_point_y <= div_tag.neg_v ? (dpp_pkg::OUT_W'(0) - mag_y) : mag_y;
            r_point_z <= dpp_pkg::OUT_W'(div_mag[2]);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_point_x;
    assign o_point_y   = r_point_y;
    assign o_point_z   = r_point_z;

endmodule
